// ----- sv/rgb_to_framebuffer_pixel_blit_defines.svh -----
// Assertion macros for the pixel blit block.
// Needs clk and rst_n in scope where a macro is used.
`ifndef RGB_TO_FRAMEBUFFER_PIXEL_BLIT_DEFINES_SVH
`define RGB_TO_FRAMEBUFFER_PIXEL_BLIT_DEFINES_SVH

// Antecedent in this cycle implies consequent in the next.
`define RGBFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RGBFB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/rgbfb_pkg.sv -----
// Shared types, constants and arithmetic helpers of the pixel blit block.
// No dependencies.
package rgbfb_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 13;
  localparam int POS_W   = 12;
  localparam int CHAN_W  = 8;
  localparam int CFG_W   = 20;
  localparam int ADDR_W  = 28;
  localparam int PIX_W   = 32;
  localparam int CNT_W   = 3;
  localparam int ENC_W   = 10;
  localparam int NCHAN   = 3;

  typedef enum logic [1:0] {
    DEPTH_16   = 2'd0,
    DEPTH_24   = 2'd1,
    DEPTH_32   = 2'd2,
    DEPTH_RSVD = 2'd3
  } depth_t;

  typedef enum logic [2:0] {
    REG_RG_LAYOUT = 3'd0,
    REG_BA_LAYOUT = 3'd1,
    REG_DEPTH     = 3'd2,
    REG_STRIDE    = 3'd3,
    REG_SCR_W     = 3'd4,
    REG_SCR_H     = 3'd5,
    REG_IMG_W     = 3'd6,
    REG_IMG_H     = 3'd7
  } cfg_idx_t;

  // Saturate a dimension to MAX_DIM.
  function automatic logic [DIM_W-1:0] dim_sat(logic [DIM_W-1:0] d);
    return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
  endfunction

  // (2^len - 2^(len mod 8)) / 255 as a sum of powers of two.
  function automatic logic [23:0] scale_k(logic [4:0] len);
    logic [23:0] k;
    k = '0;
    for (int j = 1; j <= 3; j++) begin
      if (int'(len) >= 8 * j) k = k | (24'd1 << (int'(len) - 8 * j));
    end
    return k;
  endfunction

  // floor(w / 255) for w below 2^15.
  function automatic logic [7:0] div255(logic [14:0] w);
    logic [15:0] s;
    s = 16'(w) + 16'(w[14:8]) + 16'd1;
    return s[15:8];
  endfunction

endpackage

// ----- sv/rgb_to_framebuffer_pixel_blit.sv -----
// Top level of the RGB888 to framebuffer pixel blit: config registers and
// a four-stage conversion pipeline. Depends on rgbfb_pkg and the defines header.
//
// One source pixel is taken on every clock at which start is high and busy is
// low; busy is high only during reset and in the cycle after it. Each item
// passes four register stages (decode and clip, multiply, add and divide
// fix-up, pack) before its result strobes on out_valid, one result per clock
// at most. Pixels outside the clipped draw area, or with the reserved depth
// code, give no strobe. The result ports hold for one cycle only and the
// receiver cannot hold them off. Write the config registers only while no
// item is in the pipeline.
`include "rgb_to_framebuffer_pixel_blit_defines.svh"

module rgb_to_framebuffer_pixel_blit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [2:0]                        cfg_index,
  input  logic [rgbfb_pkg::CFG_W-1:0]       cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic [rgbfb_pkg::CHAN_W-1:0]      in_red_in,
  input  logic [rgbfb_pkg::CHAN_W-1:0]      in_green_in,
  input  logic [rgbfb_pkg::CHAN_W-1:0]      in_blue_in,
  input  logic [rgbfb_pkg::POS_W-1:0]       in_src_x,
  input  logic [rgbfb_pkg::POS_W-1:0]       in_src_y,
  output logic                              out_valid,
  output logic [rgbfb_pkg::ADDR_W-1:0]      out_byte_address,
  output logic [rgbfb_pkg::PIX_W-1:0]       out_pixel_word,
  output logic [rgbfb_pkg::CNT_W-1:0]       out_byte_count
);
  import rgbfb_pkg::*;

  // Config registers
  logic [CFG_W-1:0]  rg_layout_r, ba_layout_r;
  depth_t            depth_r;
  logic [15:0]       stride_r;
  logic [DIM_W-1:0]  scr_w_r, scr_h_r, img_w_r, img_h_r;
  logic              busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rg_layout_r <= '0;
      ba_layout_r <= '0;
      depth_r     <= DEPTH_32;
      stride_r    <= '0;
      scr_w_r     <= DIM_W'(1);
      scr_h_r     <= DIM_W'(1);
      img_w_r     <= DIM_W'(1);
      img_h_r     <= DIM_W'(1);
      busy_r      <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_wr_en) begin
        unique case (cfg_idx_t'(cfg_index))
          REG_RG_LAYOUT: rg_layout_r <= cfg_data;
          REG_BA_LAYOUT: ba_layout_r <= cfg_data;
          REG_DEPTH:     depth_r     <= depth_t'(cfg_data[1:0]);
          REG_STRIDE:    stride_r    <= cfg_data[15:0];
          REG_SCR_W:     scr_w_r     <= cfg_data[DIM_W-1:0];
          REG_SCR_H:     scr_h_r     <= cfg_data[DIM_W-1:0];
          REG_IMG_W:     img_w_r     <= cfg_data[DIM_W-1:0];
          REG_IMG_H:     img_h_r     <= cfg_data[DIM_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  assign busy = busy_r;

  // Draw area and centring, from static config
  logic [DIM_W-1:0] sw, sh, iw, ih, dw, dh;
  logic [POS_W-1:0] xoff, yoff;
  logic [ENC_W-1:0] enc [NCHAN];
  logic [ENC_W-1:0] alpha_enc;

  always_comb begin
    sw = dim_sat(scr_w_r);
    sh = dim_sat(scr_h_r);
    iw = dim_sat(img_w_r);
    ih = dim_sat(img_h_r);
    dw = (iw < sw) ? iw : sw;
    dh = (ih < sh) ? ih : sh;
    xoff = (sw > iw) ? POS_W'((sw - iw) >> 1) : '0;
    yoff = (sh > ih) ? POS_W'((sh - ih) >> 1) : '0;
    enc[0]    = rg_layout_r[ENC_W-1:0];
    enc[1]    = rg_layout_r[2*ENC_W-1:ENC_W];
    enc[2]    = ba_layout_r[ENC_W-1:0];
    alpha_enc = ba_layout_r[2*ENC_W-1:ENC_W];
  end

  // Stage A: clip and centre
  logic              a_valid_r, a_valid_nxt;
  logic [CHAN_W-1:0] a_chan_r [NCHAN];
  logic [DIM_W-1:0]  a_xpos_r, a_ypos_r, a_xpos_nxt, a_ypos_nxt;

  always_comb begin
    a_valid_nxt = start && !busy_r && (depth_r != DEPTH_RSVD) &&
                  (DIM_W'(in_src_x) < dw) && (DIM_W'(in_src_y) < dh);
    a_xpos_nxt  = DIM_W'(in_src_x) + DIM_W'(xoff);
    a_ypos_nxt  = DIM_W'(in_src_y) + DIM_W'(yoff);
  end

  // Stage B: multiplies
  logic              b_valid_r;
  logic [31:0]       b_prod_r [NCHAN], b_prod_nxt [NCHAN];
  logic [14:0]       b_rem_r [NCHAN], b_rem_nxt [NCHAN];
  logic [28:0]       b_row_r, b_row_nxt;
  logic [14:0]       b_col_r, b_col_nxt;

  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      // v*(2^L-1) = 255*v*k + v*(2^(L mod 8)-1)
      b_prod_nxt[c] = 32'(a_chan_r[c]) * 32'(scale_k(enc[c][9:5]));
      b_rem_nxt[c]  = (15'(a_chan_r[c]) << enc[c][7:5]) - 15'(a_chan_r[c]);
    end
    b_row_nxt = 29'(a_ypos_r) * 29'(stride_r);
    unique case (depth_r)
      DEPTH_16:   b_col_nxt = 15'(a_xpos_r) << 1;
      DEPTH_24:   b_col_nxt = (15'(a_xpos_r) << 1) + 15'(a_xpos_r);
      DEPTH_32:   b_col_nxt = 15'(a_xpos_r) << 2;
      DEPTH_RSVD: b_col_nxt = '0;
      default:    b_col_nxt = '0;
    endcase
  end

  // Stage C: finish scaling and address
  logic              c_valid_r;
  logic [30:0]       c_field_r [NCHAN], c_field_nxt [NCHAN];
  logic [ADDR_W-1:0] c_addr_r, c_addr_nxt;

  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      c_field_nxt[c] = 31'(b_prod_r[c] + 32'(div255(b_rem_r[c])));
    end
    c_addr_nxt = ADDR_W'(b_row_r + 29'(b_col_r));
  end

  // Stage D: pack and mask
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [PIX_W-1:0]  out_pix_r, pix_nxt, pix_mask;
  logic [CNT_W-1:0]  out_cnt_r, cnt_nxt;

  always_comb begin
    pix_nxt = (~(32'hFFFF_FFFF << alpha_enc[9:5])) << alpha_enc[4:0];
    for (int c = 0; c < NCHAN; c++) begin
      pix_nxt = pix_nxt | (32'(c_field_r[c]) << enc[c][4:0]);
    end
    unique case (depth_r)
      DEPTH_16:   begin pix_mask = 32'h0000_FFFF; cnt_nxt = 3'd2; end
      DEPTH_24:   begin pix_mask = 32'h00FF_FFFF; cnt_nxt = 3'd3; end
      DEPTH_32:   begin pix_mask = 32'hFFFF_FFFF; cnt_nxt = 3'd4; end
      DEPTH_RSVD: begin pix_mask = '0;            cnt_nxt = 3'd0; end
      default:    begin pix_mask = '0;            cnt_nxt = 3'd0; end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    a_chan_r[0] <= in_red_in;
    a_chan_r[1] <= in_green_in;
    a_chan_r[2] <= in_blue_in;
    a_xpos_r    <= a_xpos_nxt;
    a_ypos_r    <= a_ypos_nxt;
    for (int c = 0; c < NCHAN; c++) begin
      b_prod_r[c]  <= b_prod_nxt[c];
      b_rem_r[c]   <= b_rem_nxt[c];
      c_field_r[c] <= c_field_nxt[c];
    end
    b_row_r    <= b_row_nxt;
    b_col_r    <= b_col_nxt;
    c_addr_r   <= c_addr_nxt;
    out_addr_r <= c_addr_r;
    out_pix_r  <= pix_nxt & pix_mask;
    out_cnt_r  <= cnt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_byte_address = out_addr_r;
  assign out_pixel_word   = out_pix_r;
  assign out_byte_count   = out_cnt_r;

  `RGBFB_ASSERT_NEXT(a_valid_moves, a_valid_r, b_valid_r, "item lost between stages A and B")
  `RGBFB_ASSERT_NEXT(c_valid_moves, c_valid_r, out_valid, "item lost before output")
  `RGBFB_ASSERT_SAME(count_range, out_valid, (out_byte_count == 3'd2 || out_byte_count == 3'd3 || out_byte_count == 3'd4), "bad byte count")
  `RGBFB_ASSERT_SAME(mask_16bpp, out_valid && out_byte_count == 3'd2, out_pixel_word[31:16] == 16'd0, "16 bpp word not masked")

endmodule

// ----- dv/rgb_to_framebuffer_pixel_blit_test.sv -----
// Testbench for rgb_to_framebuffer_pixel_blit: directed and random pixels over
// many register settings, checked against an in-bench conversion predictor.
// Depends on rgbfb_pkg and the rgb_to_framebuffer_pixel_blit top level.
`timescale 1ns / 1ps

module rgb_to_framebuffer_pixel_blit_test;
  import rgbfb_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } pixel_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  word;
    logic [CNT_W-1:0]  count;
  } fb_write_t;

  typedef struct {
    logic [CFG_W-1:0] rg;
    logic [CFG_W-1:0] ba;
    depth_t           depth;
    logic [15:0]      stride;
    logic [DIM_W-1:0] scr_w;
    logic [DIM_W-1:0] scr_h;
    logic [DIM_W-1:0] img_w;
    logic [DIM_W-1:0] img_h;
  } blit_cfg_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              start = 1'b0;
  logic              busy;
  logic [CHAN_W-1:0] in_red_in = '0;
  logic [CHAN_W-1:0] in_green_in = '0;
  logic [CHAN_W-1:0] in_blue_in = '0;
  logic [POS_W-1:0]  in_src_x = '0;
  logic [POS_W-1:0]  in_src_y = '0;
  logic              out_valid;
  logic [ADDR_W-1:0] out_byte_address;
  logic [PIX_W-1:0]  out_pixel_word;
  logic [CNT_W-1:0]  out_byte_count;

  pixel_item_t pixel_q[$];
  fb_write_t   fb_write_q[$];
  blit_cfg_t   cfg_copy;
  int          idle_pct = 0;
  int          err_count = 0;

  rgb_to_framebuffer_pixel_blit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .start            (start),
    .busy             (busy),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .in_src_x         (in_src_x),
    .in_src_y         (in_src_y),
    .out_valid        (out_valid),
    .out_byte_address (out_byte_address),
    .out_pixel_word   (out_pixel_word),
    .out_byte_count   (out_byte_count)
  );

  always #1 clk = ~clk;

  task automatic flag_error(string msg);
    if (err_count < 200) $display("mismatch: %s", msg);
    err_count++;
  endtask

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] d);
    return (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
  endfunction

  // value * (2^len - 1) / 255, truncated, then moved to its offset
  function automatic logic [31:0] scale_chan(logic [7:0] v, logic [9:0] enc);
    logic [63:0] maxv;
    logic [63:0] q;
    if (enc[9:5] == 5'd0) return 32'd0;
    maxv = (64'd1 << enc[9:5]) - 64'd1;
    q = (64'(v) * maxv) / 64'd255;
    return 32'(q << enc[4:0]);
  endfunction

  function automatic bit convert_pixel(pixel_item_t it, output fb_write_t wr);
    logic [DIM_W-1:0] sw, sh, iw, ih, dw, dh;
    logic [31:0]      xoff, yoff, pix, mask, alpha;
    logic [2:0]       nbytes;
    logic [63:0]      addr;
    wr = '0;
    sw = clamp_dim(cfg_copy.scr_w);
    sh = clamp_dim(cfg_copy.scr_h);
    iw = clamp_dim(cfg_copy.img_w);
    ih = clamp_dim(cfg_copy.img_h);
    dw = (iw < sw) ? iw : sw;
    dh = (ih < sh) ? ih : sh;
    if (cfg_copy.depth == DEPTH_RSVD) return 1'b0;
    if ({1'b0, it.x} >= dw || {1'b0, it.y} >= dh) return 1'b0;
    case (cfg_copy.depth)
      DEPTH_16: begin
        nbytes = 3'd2;
        mask   = 32'h0000_FFFF;
      end
      DEPTH_24: begin
        nbytes = 3'd3;
        mask   = 32'h00FF_FFFF;
      end
      default: begin
        nbytes = 3'd4;
        mask   = 32'hFFFF_FFFF;
      end
    endcase
    // alpha is all ones across its field whenever its length is nonzero
    if (cfg_copy.ba[19:15] == 5'd0) alpha = 32'd0;
    else alpha = 32'((((64'd1 << cfg_copy.ba[19:15]) - 64'd1)) << cfg_copy.ba[14:10]);
    pix = scale_chan(it.red, cfg_copy.rg[9:0]) | scale_chan(it.green, cfg_copy.rg[19:10])
        | scale_chan(it.blue, cfg_copy.ba[9:0]) | alpha;
    xoff = (sw > iw) ? 32'((sw - iw) >> 1) : 32'd0;
    yoff = (sh > ih) ? 32'((sh - ih) >> 1) : 32'd0;
    addr = 64'(32'(it.y) + yoff) * 64'(cfg_copy.stride)
         + 64'(32'(it.x) + xoff) * 64'(nbytes);
    wr.addr  = addr[ADDR_W-1:0];
    wr.word  = pix & mask;
    wr.count = nbytes;
    return 1'b1;
  endfunction

  // Driver: hold the item while busy, otherwise advance or idle.
  always @(posedge clk) begin
    pixel_item_t nxt;
    fb_write_t   wr;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        if (convert_pixel({in_red_in, in_green_in, in_blue_in, in_src_x, in_src_y}, wr))
          fb_write_q.push_back(wr);
      end
      if (pixel_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = pixel_q.pop_front();
        in_red_in   <= nxt.red;
        in_green_in <= nxt.green;
        in_blue_in  <= nxt.blue;
        in_src_x    <= nxt.x;
        in_src_y    <= nxt.y;
        start       <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest pending framebuffer write.
  always @(posedge clk) begin
    fb_write_t want;
    if (rst_n && out_valid) begin
      if (fb_write_q.size() == 0) begin
        flag_error($sformatf("unexpected result addr %h word %h count %0d",
                             out_byte_address, out_pixel_word, out_byte_count));
      end else begin
        want = fb_write_q.pop_front();
        if (out_byte_address !== want.addr)
          flag_error($sformatf("byte_address got %h want %h", out_byte_address, want.addr));
        if (out_pixel_word !== want.word)
          flag_error($sformatf("pixel_word got %h want %h", out_pixel_word, want.word));
        if (out_byte_count !== want.count)
          flag_error($sformatf("byte_count got %0d want %0d", out_byte_count, want.count));
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // Call only with the pipeline drained.
  task automatic program_cfg(blit_cfg_t c);
    cfg_copy = c;
    write_reg(REG_RG_LAYOUT, c.rg);
    write_reg(REG_BA_LAYOUT, c.ba);
    write_reg(REG_DEPTH, CFG_W'(c.depth));
    write_reg(REG_STRIDE, CFG_W'(c.stride));
    write_reg(REG_SCR_W, CFG_W'(c.scr_w));
    write_reg(REG_SCR_H, CFG_W'(c.scr_h));
    write_reg(REG_IMG_W, CFG_W'(c.img_w));
    write_reg(REG_IMG_H, CFG_W'(c.img_h));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic blit_cfg_t make_cfg(logic [CFG_W-1:0] rg, logic [CFG_W-1:0] ba,
                                         depth_t depth, logic [15:0] stride,
                                         logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh,
                                         logic [DIM_W-1:0] iw, logic [DIM_W-1:0] ih);
    blit_cfg_t c;
    c.rg = rg;
    c.ba = ba;
    c.depth = depth;
    c.stride = stride;
    c.scr_w = sw;
    c.scr_h = sh;
    c.img_w = iw;
    c.img_h = ih;
    return c;
  endfunction

  function automatic logic [9:0] random_enc();
    if ($urandom_range(0, 1) != 0) return 10'($urandom());
    return {5'($urandom_range(0, 8)), 5'($urandom_range(0, 24))};
  endfunction

  function automatic logic [DIM_W-1:0] random_dim(int sel);
    case (sel)
      0:       return DIM_W'($urandom_range(0, 8191));
      1:       return DIM_W'($urandom_range(4090, 4100));
      default: return DIM_W'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic blit_cfg_t random_cfg();
    blit_cfg_t c;
    int sel;
    sel = $urandom_range(0, 9);
    c.rg = {random_enc(), random_enc()};
    c.ba = {random_enc(), random_enc()};
    c.depth = ($urandom_range(0, 9) == 0) ? DEPTH_RSVD : depth_t'($urandom_range(0, 2));
    c.stride = 16'($urandom());
    c.scr_w = random_dim(sel);
    c.scr_h = random_dim(sel);
    c.img_w = random_dim(sel);
    c.img_h = random_dim(sel);
    return c;
  endfunction

  function automatic logic [7:0] random_chan();
    if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom());
  endfunction

  // Mostly land inside the draw area; the rest spread over the whole field.
  function automatic pixel_item_t random_pixel();
    pixel_item_t      p;
    logic [DIM_W-1:0] dw, dh;
    dw = (clamp_dim(cfg_copy.img_w) < clamp_dim(cfg_copy.scr_w)) ?
         clamp_dim(cfg_copy.img_w) : clamp_dim(cfg_copy.scr_w);
    dh = (clamp_dim(cfg_copy.img_h) < clamp_dim(cfg_copy.scr_h)) ?
         clamp_dim(cfg_copy.img_h) : clamp_dim(cfg_copy.scr_h);
    p.red   = random_chan();
    p.green = random_chan();
    p.blue  = random_chan();
    if (dw != 0 && dh != 0 && $urandom_range(0, 99) < 85) begin
      p.x = POS_W'($urandom_range(0, int'(dw) - 1));
      p.y = POS_W'($urandom_range(0, int'(dh) - 1));
    end else begin
      p.x = POS_W'($urandom());
      p.y = POS_W'($urandom());
    end
    return p;
  endfunction

  task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [POS_W-1:0] x, logic [POS_W-1:0] y);
    pixel_q.push_back({r, g, b, x, y});
  endtask

  // Wait for every item to be taken and every write to arrive, then let the
  // pipeline empty of items that give no result.
  task automatic drain_pipeline();
    do @(negedge clk); while (pixel_q.size() != 0 || start || fb_write_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int idle_table[3];
    idle_table = '{0, 60, 22};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: one-pixel screen, 32 bpp, all-zero layout
    cfg_copy = make_cfg('0, '0, DEPTH_32, 16'd0, 13'd1, 13'd1, 13'd1, 13'd1);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 12'd0, 12'd0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 12'd1, 12'd0);
    push_pixel(8'h00, 8'h00, 8'h00, 12'd0, 12'd1);
    drain_pipeline();

    // 565 at 16 bpp, image centred on a larger screen
    program_cfg(make_cfg({10'd197, 10'd171}, {10'd0, 10'd160}, DEPTH_16, 16'd1280,
                         13'd640, 13'd480, 13'd320, 13'd240));
    push_pixel(8'h00, 8'h00, 8'h00, 12'd0, 12'd0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 12'd319, 12'd239);
    push_pixel(8'hFF, 8'h00, 8'h00, 12'd1, 12'd0);
    push_pixel(8'h00, 8'hFF, 8'h00, 12'd0, 12'd1);
    push_pixel(8'h00, 8'h00, 8'hFF, 12'd160, 12'd120);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 12'd320, 12'd0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 12'd0, 12'd240);
    drain_pipeline();

    // longest fields at the top offset, oversize screen, widest stride
    program_cfg(make_cfg(20'hFFFFF, 20'hFFFFF, DEPTH_32, 16'hFFFF,
                         13'd8191, 13'd8191, 13'd4096, 13'd4096));
    push_pixel(8'hFF, 8'hFF, 8'hFF, 12'd4095, 12'd4095);
    push_pixel(8'h00, 8'h00, 8'h00, 12'd0, 12'd0);
    push_pixel(8'd1, 8'd128, 8'd254, 12'd2048, 12'd7);
    drain_pipeline();

    // 888 at 24 bpp: alpha falls above the kept bytes, screen shorter than image
    program_cfg(make_cfg({10'd264, 10'd272}, {10'd280, 10'd256}, DEPTH_24, 16'd48,
                         13'd16, 13'd4, 13'd16, 13'd16));
    push_pixel(8'hFF, 8'd128, 8'd1, 12'd15, 12'd3);
    push_pixel(8'h00, 8'h00, 8'h00, 12'd0, 12'd0);
    push_pixel(8'd9, 8'd9, 8'd9, 12'd0, 12'd4);
    drain_pipeline();

    // overlapping fields, image wider than screen so the x offset clamps
    program_cfg(make_cfg({10'd256, 10'd260}, {10'd156, 10'd404}, DEPTH_32, 16'd100,
                         13'd4, 13'd9, 13'd9, 13'd4));
    push_pixel(8'd200, 8'd100, 8'd50, 12'd3, 12'd3);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 12'd4, 12'd0);
    drain_pipeline();

    // reserved depth drops everything
    program_cfg(make_cfg({10'd256, 10'd260}, {10'd156, 10'd404}, DEPTH_RSVD, 16'd100,
                         13'd4, 13'd9, 13'd9, 13'd4));
    push_pixel(8'd200, 8'd100, 8'd50, 12'd0, 12'd0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 12'd1, 12'd1);
    drain_pipeline();

    // zero dimensions leave an empty draw area
    program_cfg(make_cfg(20'h12345, 20'h6789A, DEPTH_32, 16'd7,
                         13'd16, 13'd0, 13'd0, 13'd16));
    push_pixel(8'hFF, 8'hFF, 8'hFF, 12'd0, 12'd0);
    push_pixel(8'h55, 8'hAA, 8'h55, 12'd2, 12'd3);
    drain_pipeline();

    for (int ph = 0; ph < 19; ph++) begin
      program_cfg(random_cfg());
      idle_pct = idle_table[ph % 3];
      for (int i = 0; i < 50; i++) pixel_q.push_back(random_pixel());
      drain_pipeline();
    end
    idle_pct = 0;

    if (err_count == 0) $display("[rgb_to_framebuffer_pixel_blit] OK");
    else $display("[rgb_to_framebuffer_pixel_blit] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[rgb_to_framebuffer_pixel_blit] ERROR");
    $finish;
  end

endmodule
